@@ design/tagged_packet_buffer_pool_defines.svh @@
// Assertion macros for the tagged packet buffer pool.
// No dependencies; included by files that carry concurrent checks.
`ifndef TAGGED_PACKET_BUFFER_POOL_DEFINES_SVH
`define TAGGED_PACKET_BUFFER_POOL_DEFINES_SVH

// same-cycle implication
`define TPBP_CHECK(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TPBP_CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/tpbp_pkg.sv @@
// Shared types and constants for the tagged packet buffer pool.
// No dependencies; imported by tpbp_cell, the top level and the testbench.
package tpbp_pkg;

    localparam int SLOTS      = 16;
    localparam int IDX_W      = 8;
    localparam int CODE_W     = 8;
    localparam int KIND_W     = 3;
    localparam int ADDR_W     = 64;
    localparam int SLOT_OUT_W = 4;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CODE_W-1:0] RST_CODE_FREE         = 8'd0;
    localparam logic [CODE_W-1:0] RST_CODE_POOL         = 8'd1;
    localparam logic [CODE_W-1:0] RST_CODE_MAC_TO_UPPER = 8'd2;
    localparam logic [CODE_W-1:0] RST_CODE_MAC          = 8'd3;
    localparam logic [CODE_W-1:0] RST_CODE_UPPER_TO_MAC = 8'd4;
    localparam logic [CODE_W-1:0] RST_CODE_UPPER        = 8'd5;

    typedef enum logic [2:0] {
        ACT_ALLOC      = 3'd0,
        ACT_REL_SLOT   = 3'd1,
        ACT_REL_OWNER  = 3'd2,
        ACT_FIND_SENT  = 3'd3,
        ACT_FIND_RECV  = 3'd4,
        ACT_FIND_DATA  = 3'd5,
        ACT_FIND_ADV   = 3'd6,
        ACT_SET_TAGS   = 3'd7
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FREE         = 3'd0,
        CFG_POOL         = 3'd1,
        CFG_MAC_TO_UPPER = 3'd2,
        CFG_MAC          = 3'd3,
        CFG_UPPER_TO_MAC = 3'd4,
        CFG_UPPER        = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [CODE_W-1:0] free_c;
        logic [CODE_W-1:0] pool_c;
        logic [CODE_W-1:0] mac_to_upper_c;
        logic [CODE_W-1:0] mac_c;
        logic [CODE_W-1:0] upper_to_mac_c;
        logic [CODE_W-1:0] upper_c;
    } t_codes;

    // transaction travelling down the cell row, with its running result
    typedef struct packed {
        t_action               action;
        logic [IDX_W-1:0]      slot_index;
        logic [CODE_W-1:0]     owner;
        logic [CODE_W-1:0]     creator;
        logic [KIND_W-1:0]     kind;
        logic [ADDR_W-1:0]     addr;
        logic                  found;
        logic [SLOT_OUT_W-1:0] slot;
    } t_op;

endpackage

@@ design/tagged_packet_buffer_pool.sv @@
// Tagged packet buffer pool: a row of SLOTS cells, one slot each (16 here).
// Each cell registers the transaction once on its way to o_valid.
// Throughput: one transaction per cycle; the whole row freezes while the
// result register holds a stalled result.
// Reset (synchronous, active low): every slot free with code 0 and no
// address, code registers to their defaults, row empty.
`include "tagged_packet_buffer_pool_defines.svh"

module tagged_packet_buffer_pool
    import tpbp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [2:0]            i_action,
    input  logic [IDX_W-1:0]      i_slot_index,
    input  logic [CODE_W-1:0]     i_owner_code,
    input  logic [CODE_W-1:0]     i_creator_code,
    input  logic [KIND_W-1:0]     i_hop_kind,
    input  logic [ADDR_W-1:0]     i_hop_address,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_found,
    output logic [SLOT_OUT_W-1:0] o_slot,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CODE_W-1:0]     i_cfg_data
);

    t_codes r_codes;
    logic   adv;
    logic   w_valid [0:SLOTS];
    t_op    w_op    [0:SLOTS];
    logic   any_busy;

    assign adv         = !(w_valid[SLOTS] && i_stall);
    assign o_stall     = !adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes.free_c         <= RST_CODE_FREE;
            r_codes.pool_c         <= RST_CODE_POOL;
            r_codes.mac_to_upper_c <= RST_CODE_MAC_TO_UPPER;
            r_codes.mac_c          <= RST_CODE_MAC;
            r_codes.upper_to_mac_c <= RST_CODE_UPPER_TO_MAC;
            r_codes.upper_c        <= RST_CODE_UPPER;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_FREE:         r_codes.free_c         <= i_cfg_data;
                CFG_POOL:         r_codes.pool_c         <= i_cfg_data;
                CFG_MAC_TO_UPPER: r_codes.mac_to_upper_c <= i_cfg_data;
                CFG_MAC:          r_codes.mac_c          <= i_cfg_data;
                CFG_UPPER_TO_MAC: r_codes.upper_to_mac_c <= i_cfg_data;
                CFG_UPPER:        r_codes.upper_c        <= i_cfg_data;
                default: begin
                    r_codes <= r_codes;
                end
            endcase
        end
    end

    always_comb begin
        w_valid[0]         = i_valid;
        w_op[0].action     = t_action'(i_action);
        w_op[0].slot_index = i_slot_index;
        w_op[0].owner      = i_owner_code;
        w_op[0].creator    = i_creator_code;
        w_op[0].kind       = i_hop_kind;
        w_op[0].addr       = i_hop_address;
        w_op[0].found      = 1'b0;
        w_op[0].slot       = '0;
    end

    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        tpbp_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_adv      (adv),
            .i_cell_idx (IDX_W'(k)),
            .i_codes    (r_codes),
            .i_valid    (w_valid[k]),
            .i_op       (w_op[k]),
            .o_valid    (w_valid[k+1]),
            .o_op       (w_op[k+1])
        );
    end

    assign o_valid = w_valid[SLOTS];
    assign o_found = w_op[SLOTS].found;
    assign o_slot  = w_op[SLOTS].slot;

    always_comb begin
        any_busy = 1'b0;
        for (int k = 1; k <= SLOTS; k++) begin
            any_busy = any_busy | w_valid[k];
        end
    end

    `TPBP_CHECK(a_fail_slot_zero, i_clk, i_rst_n, o_valid && !o_found, o_slot == '0,
        "failed result carries a nonzero slot")
    `TPBP_CHECK_NEXT(a_row_holds, i_clk, i_rst_n, i_rst_n && w_valid[1] && o_stall,
        w_valid[1], "first cell lost a transaction while the row was frozen")
    `TPBP_CHECK_NEXT(a_no_phantom, i_clk, i_rst_n, i_rst_n && !any_busy && !i_valid,
        !o_valid, "result appeared from an empty row")

endmodule

@@ design/tpbp_cell.sv @@
// One slot of the pool: its tags plus one stage of the transaction row.
// Depends on tpbp_pkg.
module tpbp_cell
    import tpbp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic [IDX_W-1:0] i_cell_idx,
    input  t_codes           i_codes,
    input  logic             i_valid,
    input  t_op              i_op,
    output logic             o_valid,
    output t_op              o_op
);

    logic [CODE_W-1:0] r_owner, n_owner;
    logic [CODE_W-1:0] r_creator, n_creator;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic              r_valid;
    t_op               r_op, n_op;
    logic              hit_idx;
    logic              mtu_owner;
    logic              utm_owner;

    assign hit_idx   = (i_op.slot_index == i_cell_idx);
    assign mtu_owner = (r_owner == i_codes.mac_to_upper_c);
    assign utm_owner = (r_owner == i_codes.upper_to_mac_c);

    always_comb begin
        n_owner   = r_owner;
        n_creator = r_creator;
        n_kind    = r_kind;
        n_addr    = r_addr;
        n_op      = i_op;
        case (i_op.action)
            ACT_ALLOC: begin
                if (!i_op.found && r_owner == i_codes.free_c) begin
                    n_owner    = i_codes.pool_c;
                    n_op.found = 1'b1;
                    n_op.slot  = i_cell_idx[SLOT_OUT_W-1:0];
                end
            end
            ACT_REL_SLOT: begin
                if (hit_idx) begin
                    n_owner    = i_codes.free_c;
                    n_creator  = i_codes.free_c;
                    n_kind     = '0;
                    n_addr     = '0;
                    n_op.found = 1'b1;
                    n_op.slot  = i_cell_idx[SLOT_OUT_W-1:0];
                end
            end
            ACT_REL_OWNER: begin
                if (r_owner == i_op.owner) begin
                    n_owner   = i_codes.free_c;
                    n_creator = i_codes.free_c;
                    n_kind    = '0;
                    n_addr    = '0;
                    // lowest freed index wins
                    if (!i_op.found) begin
                        n_op.found = 1'b1;
                        n_op.slot  = i_cell_idx[SLOT_OUT_W-1:0];
                    end
                end
            end
            ACT_FIND_SENT: begin
                if (!i_op.found && mtu_owner && r_creator != i_codes.mac_c) begin
                    n_op.found = 1'b1;
                    n_op.slot  = i_cell_idx[SLOT_OUT_W-1:0];
                end
            end
            ACT_FIND_RECV: begin
                if (!i_op.found && mtu_owner && r_creator == i_codes.mac_c) begin
                    n_op.found = 1'b1;
                    n_op.slot  = i_cell_idx[SLOT_OUT_W-1:0];
                end
            end
            ACT_FIND_DATA: begin
                // a kind of zero means no address and never matches
                if (!i_op.found && utm_owner && i_op.kind != '0 &&
                    r_kind == i_op.kind && r_addr == i_op.addr) begin
                    n_op.found = 1'b1;
                    n_op.slot  = i_cell_idx[SLOT_OUT_W-1:0];
                end
            end
            ACT_FIND_ADV: begin
                if (!i_op.found && utm_owner && r_creator == i_codes.upper_c) begin
                    n_op.found = 1'b1;
                    n_op.slot  = i_cell_idx[SLOT_OUT_W-1:0];
                end
            end
            ACT_SET_TAGS: begin
                if (hit_idx) begin
                    n_owner    = i_op.owner;
                    n_creator  = i_op.creator;
                    n_kind     = i_op.kind;
                    n_addr     = i_op.addr;
                    n_op.found = 1'b1;
                    n_op.slot  = i_cell_idx[SLOT_OUT_W-1:0];
                end
            end
            default: begin
                n_op = i_op;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner   <= RST_CODE_FREE;
            r_creator <= RST_CODE_FREE;
            r_kind    <= '0;
            r_addr    <= '0;
            r_valid   <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_owner   <= n_owner;
                r_creator <= n_creator;
                r_kind    <= n_kind;
                r_addr    <= n_addr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_op <= n_op;
        end
    end

    assign o_valid = r_valid;
    assign o_op    = r_op;

endmodule

@@ tb/tagged_packet_buffer_pool_tb.sv @@
// Self-checking testbench for tagged_packet_buffer_pool: directed and random tag-table traffic.
// Depends on tpbp_pkg and the tagged_packet_buffer_pool RTL; every result is predicted in-bench.
`timescale 1ns / 100ps

module tagged_packet_buffer_pool_tb
    import tpbp_pkg::*;
;

    localparam int RUN_LIMIT    = 200000;
    localparam int RANDOM_ITEMS = 240;
    // index with no register behind it; writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    typedef struct packed {
        t_action           act;
        logic [IDX_W-1:0]  idx;
        logic [CODE_W-1:0] owner;
        logic [CODE_W-1:0] creator;
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] addr;
    } t_pool_req;

    typedef struct packed {
        logic                  found;
        logic [SLOT_OUT_W-1:0] slot;
    } t_pool_resp;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_valid        = 1'b0;
    logic                  o_stall;
    logic [2:0]            i_action       = '0;
    logic [IDX_W-1:0]      i_slot_index   = '0;
    logic [CODE_W-1:0]     i_owner_code   = '0;
    logic [CODE_W-1:0]     i_creator_code = '0;
    logic [KIND_W-1:0]     i_hop_kind     = '0;
    logic [ADDR_W-1:0]     i_hop_address  = '0;
    logic                  o_valid;
    logic                  i_stall        = 1'b0;
    logic                  o_found;
    logic [SLOT_OUT_W-1:0] o_slot;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CODE_W-1:0]     i_cfg_data     = '0;

    // shadow copy of the slot table and code registers
    t_codes            codes;
    logic [CODE_W-1:0] owner_of    [SLOTS];
    logic [CODE_W-1:0] creator_of  [SLOTS];
    logic [KIND_W-1:0] hop_kind_of [SLOTS];
    logic [ADDR_W-1:0] hop_addr_of [SLOTS];

    t_pool_resp        pending_resp [$];
    int unsigned       err_count   = 0;
    int unsigned       cycle_count = 0;
    int unsigned       burst_left  = 0;
    bit                tx_idle_on  = 1'b1;
    bit                rx_stall_on = 1'b1;
    logic [31:0]       stall_pat   = 32'hC3A5_0F96;

    // a few next-hop addresses reused so that data searches hit
    logic [KIND_W-1:0] hop_kinds [4];
    logic [ADDR_W-1:0] hop_addrs [4];

    tagged_packet_buffer_pool uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_slot_index   (i_slot_index),
        .i_owner_code   (i_owner_code),
        .i_creator_code (i_creator_code),
        .i_hop_kind     (i_hop_kind),
        .i_hop_address  (i_hop_address),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_found        (o_found),
        .o_slot         (o_slot),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void free_slot(int s);
        owner_of[s]    = codes.free_c;
        creator_of[s]  = codes.free_c;
        hop_kind_of[s] = '0;
        hop_addr_of[s] = '0;
    endfunction

    function automatic bit search_hit(t_pool_req r, int s);
        case (r.act)
            ACT_FIND_SENT: return owner_of[s] == codes.mac_to_upper_c &&
                                  creator_of[s] != codes.mac_c;
            ACT_FIND_RECV: return owner_of[s] == codes.mac_to_upper_c &&
                                  creator_of[s] == codes.mac_c;
            ACT_FIND_DATA: return owner_of[s] == codes.upper_to_mac_c && r.kind != '0 &&
                                  hop_kind_of[s] == r.kind && hop_addr_of[s] == r.addr;
            default:       return owner_of[s] == codes.upper_to_mac_c &&
                                  creator_of[s] == codes.upper_c;
        endcase
    endfunction

    // applies one transaction to the shadow table and returns its result
    function automatic t_pool_resp pool_apply(t_pool_req r);
        t_pool_resp res;
        res = '0;
        case (r.act)
            ACT_ALLOC: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (!res.found && owner_of[s] == codes.free_c) begin
                        owner_of[s] = codes.pool_c;
                        res.found   = 1'b1;
                        res.slot    = SLOT_OUT_W'(s);
                    end
                end
            end
            ACT_REL_SLOT: begin
                if (r.idx < SLOTS) begin
                    free_slot(int'(r.idx));
                    res.found = 1'b1;
                    res.slot  = SLOT_OUT_W'(r.idx);
                end
            end
            ACT_REL_OWNER: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (owner_of[s] == r.owner) begin
                        if (!res.found) begin
                            res.found = 1'b1;
                            res.slot  = SLOT_OUT_W'(s);
                        end
                        free_slot(s);
                    end
                end
            end
            ACT_SET_TAGS: begin
                if (r.idx < SLOTS) begin
                    owner_of[r.idx]    = r.owner;
                    creator_of[r.idx]  = r.creator;
                    hop_kind_of[r.idx] = r.kind;
                    hop_addr_of[r.idx] = r.addr;
                    res.found = 1'b1;
                    res.slot  = SLOT_OUT_W'(r.idx);
                end
            end
            default: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (!res.found && search_hit(r, s)) begin
                        res.found = 1'b1;
                        res.slot  = SLOT_OUT_W'(s);
                    end
                end
            end
        endcase
        return res;
    endfunction

    function automatic t_pool_req req_of(t_action act, logic [IDX_W-1:0] idx,
                                         logic [CODE_W-1:0] owner,
                                         logic [CODE_W-1:0] creator,
                                         logic [KIND_W-1:0] kind,
                                         logic [ADDR_W-1:0] addr);
        t_pool_req r;
        r.act     = act;
        r.idx     = idx;
        r.owner   = owner;
        r.creator = creator;
        r.kind    = kind;
        r.addr    = addr;
        return r;
    endfunction

    function automatic t_pool_req random_req();
        t_pool_req   r;
        int unsigned pick;
        if ($urandom_range(3) == 0)
            r.act = ACT_SET_TAGS;
        else
            r.act = t_action'($urandom_range(7));
        if ($urandom_range(7) == 0)
            r.idx = IDX_W'($urandom_range(255));
        else
            r.idx = IDX_W'($urandom_range(SLOTS - 1));
        case ($urandom_range(5))
            0:       r.owner = codes.free_c;
            1:       r.owner = codes.pool_c;
            2:       r.owner = codes.mac_to_upper_c;
            3:       r.owner = codes.upper_to_mac_c;
            default: r.owner = CODE_W'($urandom);
        endcase
        case ($urandom_range(3))
            0:       r.creator = codes.mac_c;
            1:       r.creator = codes.upper_c;
            2:       r.creator = codes.free_c;
            default: r.creator = CODE_W'($urandom);
        endcase
        pick = $urandom_range(3);
        if ($urandom_range(4) == 0) begin
            r.kind = KIND_W'($urandom);
            r.addr = {$urandom, $urandom};
        end else begin
            r.kind = hop_kinds[pick];
            r.addr = hop_addrs[pick];
        end
        return r;
    endfunction

    task automatic note_error(input string what, input logic [63:0] want_v,
                              input logic [63:0] got_v);
        $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want_v, got_v);
        err_count++;
    endtask

    // sends one transaction; bursts of random length, separated by random gaps while tx_idle_on is set
    task automatic push_req(input t_pool_req r);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (tx_idle_on) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid        <= 1'b1;
        i_action       <= r.act;
        i_slot_index   <= r.idx;
        i_owner_code   <= r.owner;
        i_creator_code <= r.creator;
        i_hop_kind     <= r.kind;
        i_hop_address  <= r.addr;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // the first wait lets the predictor log a transaction accepted at this edge
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_resp.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_code(input logic [CFG_IDX_W-1:0] idx, input logic [CODE_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_codes(input t_codes c);
        wait_drained();
        write_code(CFG_FREE,         c.free_c);
        write_code(CFG_POOL,         c.pool_c);
        write_code(CFG_MAC_TO_UPPER, c.mac_to_upper_c);
        write_code(CFG_MAC,          c.mac_c);
        write_code(CFG_UPPER_TO_MAC, c.upper_to_mac_c);
        write_code(CFG_UPPER,        c.upper_c);
    endtask

    task automatic test_reset_defaults();
        push_req(req_of(ACT_ALLOC, '0, '0, '0, '0, '0));
        push_req(req_of(ACT_FIND_SENT, '0, '0, '0, '0, '0));
        push_req(req_of(ACT_FIND_ADV, '0, '0, '0, '0, '0));
        push_req(req_of(ACT_REL_OWNER, '0, RST_CODE_UPPER, '0, '0, '0));
        push_req(req_of(ACT_ALLOC, '0, '0, '0, '0, '0));
    endtask

    task automatic test_slot_searches();
        push_req(req_of(ACT_SET_TAGS, 8'd15, RST_CODE_MAC_TO_UPPER, 8'hFF, 3'd7, '1));
        push_req(req_of(ACT_FIND_SENT, '0, '0, '0, '0, '0));
        push_req(req_of(ACT_FIND_RECV, '0, '0, '0, '0, '0));
        push_req(req_of(ACT_SET_TAGS, 8'd3, RST_CODE_MAC_TO_UPPER, RST_CODE_MAC, '0, '0));
        push_req(req_of(ACT_FIND_RECV, '0, '0, '0, '0, '0));
        push_req(req_of(ACT_FIND_SENT, '0, '0, '0, '0, '0));
        push_req(req_of(ACT_SET_TAGS, 8'd9, RST_CODE_UPPER_TO_MAC, RST_CODE_UPPER, 3'd1, '0));
        push_req(req_of(ACT_FIND_ADV, '0, '0, '0, '0, '0));
    endtask

    // a stored kind of zero means no address and must never match
    task automatic test_find_data_kinds();
        push_req(req_of(ACT_SET_TAGS, 8'd6, RST_CODE_UPPER_TO_MAC, '0, 3'd7, '1));
        push_req(req_of(ACT_FIND_DATA, '0, '0, '0, 3'd7, '1));
        push_req(req_of(ACT_FIND_DATA, '0, '0, '0, 3'd7, 64'hFFFF_FFFF_FFFF_FFFE));
        push_req(req_of(ACT_FIND_DATA, '0, '0, '0, 3'd1, '0));
        push_req(req_of(ACT_SET_TAGS, 8'd12, RST_CODE_UPPER_TO_MAC, '0, '0, '0));
        push_req(req_of(ACT_FIND_DATA, '0, '0, '0, '0, '0));
    endtask

    task automatic test_release_range();
        push_req(req_of(ACT_REL_SLOT, 8'hFF, '0, '0, '0, '0));
        push_req(req_of(ACT_REL_SLOT, IDX_W'(SLOTS), '0, '0, '0, '0));
        push_req(req_of(ACT_SET_TAGS, 8'd200, 8'hFF, 8'hFF, 3'd7, '1));
        push_req(req_of(ACT_REL_SLOT, 8'd15, '0, '0, '0, '0));
    endtask

    task automatic test_release_owner();
        push_req(req_of(ACT_REL_OWNER, '0, RST_CODE_MAC_TO_UPPER, '0, '0, '0));
        push_req(req_of(ACT_REL_OWNER, '0, RST_CODE_MAC_TO_UPPER, '0, '0, '0));
    endtask

    // a new free code does not retag the table, so the pool looks full
    task automatic test_code_registers();
        wait_drained();
        write_code(CFG_FREE, 8'hFF);
        write_code(CFG_SPARE, 8'hA5);
        push_req(req_of(ACT_ALLOC, '0, '0, '0, '0, '0));
        push_req(req_of(ACT_REL_SLOT, 8'd0, '0, '0, '0, '0));
        push_req(req_of(ACT_ALLOC, '0, '0, '0, '0, '0));
    endtask

    task automatic test_random_traffic(input t_codes c);
        load_codes(c);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 60 == 0) begin
                tx_idle_on  = $urandom_range(3) != 0;
                rx_stall_on = $urandom_range(3) != 0;
            end
            push_req(random_req());
        end
    endtask

    // receiver stall pattern, reloaded now and then
    always @(posedge i_clk) begin
        i_stall   <= rx_stall_on ? stall_pat[0] : 1'b0;
        stall_pat <= ($urandom_range(63) == 0) ? $urandom : {stall_pat[0], stall_pat[31:1]};
    end

    // predict on every accepted transaction and register write
    always @(posedge i_clk) begin
        t_pool_req seen;
        if (i_rst_n && i_valid && !o_stall) begin
            seen = req_of(t_action'(i_action), i_slot_index, i_owner_code, i_creator_code,
                          i_hop_kind, i_hop_address);
            pending_resp.push_back(pool_apply(seen));
        end
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FREE:         codes.free_c         = i_cfg_data;
                CFG_POOL:         codes.pool_c         = i_cfg_data;
                CFG_MAC_TO_UPPER: codes.mac_to_upper_c = i_cfg_data;
                CFG_MAC:          codes.mac_c          = i_cfg_data;
                CFG_UPPER_TO_MAC: codes.upper_to_mac_c = i_cfg_data;
                CFG_UPPER:        codes.upper_c        = i_cfg_data;
                default: ;
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_pool_resp want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_resp.size() == 0) begin
                note_error("unexpected result", '0, {o_found, o_slot});
            end else begin
                want = pending_resp.pop_front();
                if (o_found !== want.found) note_error("found", want.found, o_found);
                if (o_slot !== want.slot) note_error("slot", want.slot, o_slot);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        codes = '{free_c: RST_CODE_FREE, pool_c: RST_CODE_POOL,
                  mac_to_upper_c: RST_CODE_MAC_TO_UPPER, mac_c: RST_CODE_MAC,
                  upper_to_mac_c: RST_CODE_UPPER_TO_MAC, upper_c: RST_CODE_UPPER};
        for (int s = 0; s < SLOTS; s++) free_slot(s);
        hop_kinds[0] = 3'd7;
        hop_addrs[0] = '1;
        hop_kinds[1] = 3'd1;
        hop_addrs[1] = {$urandom, $urandom};
        hop_kinds[2] = '0;
        hop_addrs[2] = '0;
        hop_kinds[3] = KIND_W'($urandom_range(1, 7));
        hop_addrs[3] = {32'h0, $urandom};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_slot_searches();
        test_find_data_kinds();
        test_release_range();
        test_release_owner();
        test_code_registers();

        test_random_traffic('{RST_CODE_FREE, RST_CODE_POOL, RST_CODE_MAC_TO_UPPER,
                              RST_CODE_MAC, RST_CODE_UPPER_TO_MAC, RST_CODE_UPPER});
        test_random_traffic('{8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01, 8'hFE});
        // overlapping codes: pool equals free, all search codes equal
        test_random_traffic('{8'h07, 8'h07, 8'h09, 8'h09, 8'h09, 8'h09});
        test_random_traffic('{CODE_W'($urandom), CODE_W'($urandom), CODE_W'($urandom),
                              CODE_W'($urandom), CODE_W'($urandom), CODE_W'($urandom)});
        test_random_traffic('{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF});
        test_random_traffic('{CODE_W'($urandom_range(3)), CODE_W'($urandom_range(3)),
                              CODE_W'($urandom_range(3)), CODE_W'($urandom_range(3)),
                              CODE_W'($urandom_range(3)), CODE_W'($urandom_range(3))});

        wait_drained();
        repeat (SLOTS + 8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/tpbp_pkg.sv
design/tpbp_cell.sv
design/tagged_packet_buffer_pool.sv
tb/tagged_packet_buffer_pool_tb.sv
